/* hdl/htw_pkg.sv */
// ----------------------------------------------------------------------------
// htw_pkg
// Shared constants, codes and types of the hierarchical timer wheel.
// ----------------------------------------------------------------------------
package htw_pkg;

    localparam int MAX_TIMERS_DEF = 64;
    localparam int ROOT_BITS_DEF  = 8;
    localparam int LEVEL_BITS_DEF = 6;
    localparam int RESULT_CAP     = 64;

    localparam logic [1:0] MODE_ADD  = 2'd0;
    localparam logic [1:0] MODE_KILL = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;

    localparam logic [2:0] KIND_ADDED  = 3'd0;
    localparam logic [2:0] KIND_FULL   = 3'd1;
    localparam logic [2:0] KIND_KILLED = 3'd2;
    localparam logic [2:0] KIND_MISS   = 3'd3;
    localparam logic [2:0] KIND_FIRED  = 3'd4;

    localparam logic [31:0] LIMIT_FOREVER = 32'hffff_ffff;

    typedef struct packed {
        logic [31:0] expiry;
        logic [31:0] period;
        logic [31:0] limit;
        logic [31:0] fired;
        logic [31:0] id;
    } ent_t;

    typedef enum logic [4:0] {
        CMD_CLR, CMD_IDLE, CMD_ASCAN, CMD_AFILL, CMD_FRD, CMD_FWR, CMD_FLINK,
        CMD_KRD, CMD_KCMP, CMD_URD, CMD_UDAT, CMD_UWR, CMD_EMIT,
        CMD_CRD, CMD_CDET, CMD_CE, CMD_CDAT, CMD_CNX,
        CMD_TRD, CMD_TDET, CMD_TE, CMD_TDAT, CMD_TFIRE, CMD_TNX, CMD_TEND
    } cmd_t;

    typedef struct packed {
        logic       acc;
        logic [1:0] mode;
        logic       root_zero;
        logic       used_c;
        logic       c_last;
        logic       kill_hit;
        logic       tail_nil;
        logic       e_nil;
        logic       casc_brk;
        logic       out_free;
        logic       clr_last;
        logic       fire_stall;
        logic       again;
        logic       pend_v;
    } stat_t;

endpackage

/* hdl/htw_ram.sv */
// ----------------------------------------------------------------------------
// htw_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module htw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/htw_ctrl.sv */
// ----------------------------------------------------------------------------
// htw_ctrl
// Sequencer: steps the datapath through add, kill, cascade and fire walks.
// ----------------------------------------------------------------------------
module htw_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  htw_pkg::stat_t stat,
    output htw_pkg::cmd_t  cmd
);

    typedef enum logic [24:0] {
        ST_CLR   = 25'h0000001, ST_IDLE  = 25'h0000002, ST_ASCAN = 25'h0000004,
        ST_AFILL = 25'h0000008, ST_FRD   = 25'h0000010, ST_FWR   = 25'h0000020,
        ST_FLINK = 25'h0000040, ST_KRD   = 25'h0000080, ST_KCMP  = 25'h0000100,
        ST_URD   = 25'h0000200, ST_UDAT  = 25'h0000400, ST_UWR   = 25'h0000800,
        ST_EMIT  = 25'h0001000, ST_CRD   = 25'h0002000, ST_CDET  = 25'h0004000,
        ST_CE    = 25'h0008000, ST_CDAT  = 25'h0010000, ST_CNX   = 25'h0020000,
        ST_TRD   = 25'h0040000, ST_TDET  = 25'h0080000, ST_TE    = 25'h0100000,
        ST_TDAT  = 25'h0200000, ST_TFIRE = 25'h0400000, ST_TNX   = 25'h0800000,
        ST_TEND  = 25'h1000000
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        case (state_reg)
            ST_CLR: begin
                if (stat.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (stat.acc) begin
                    case (stat.mode)
                        htw_pkg::MODE_ADD:  state_next = ST_ASCAN;
                        htw_pkg::MODE_KILL: state_next = ST_KRD;
                        htw_pkg::MODE_TICK: state_next = stat.root_zero ? ST_CRD : ST_TRD;
                        default:            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ASCAN: begin
                if (!stat.used_c) state_next = ST_AFILL;
                else if (stat.c_last) state_next = ST_EMIT;
            end
            ST_AFILL: begin
                state_next = ST_FRD;
                ret_next   = ST_EMIT;
            end
            ST_FRD:   state_next = ST_FWR;
            ST_FWR:   state_next = stat.tail_nil ? ret_reg : ST_FLINK;
            ST_FLINK: state_next = ret_reg;
            ST_KRD:   state_next = ST_KCMP;
            ST_KCMP: begin
                if (stat.kill_hit) state_next = ST_URD;
                else if (stat.c_last) state_next = ST_EMIT;
                else state_next = ST_KRD;
            end
            ST_URD:   state_next = ST_UDAT;
            ST_UDAT:  state_next = ST_UWR;
            ST_UWR:   state_next = ST_EMIT;
            ST_EMIT: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            ST_CRD:   state_next = ST_CDET;
            ST_CDET:  state_next = ST_CE;
            ST_CE: begin
                if (!stat.e_nil) state_next = ST_CDAT;
                else state_next = stat.casc_brk ? ST_TRD : ST_CRD;
            end
            ST_CDAT: begin
                state_next = ST_FRD;
                ret_next   = ST_CNX;
            end
            ST_CNX:   state_next = ST_CE;
            ST_TRD:   state_next = ST_TDET;
            ST_TDET:  state_next = ST_TE;
            ST_TE:    state_next = stat.e_nil ? ST_TEND : ST_TDAT;
            ST_TDAT:  state_next = ST_TFIRE;
            ST_TFIRE: begin
                if (!stat.fire_stall) begin
                    if (stat.again) begin
                        state_next = ST_FRD;
                        ret_next   = ST_TNX;
                    end else begin
                        state_next = ST_TNX;
                    end
                end
            end
            ST_TNX:   state_next = ST_TE;
            ST_TEND: begin
                if (!stat.pend_v || stat.out_free) state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
            ret_reg   <= ST_IDLE;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_comb begin
        case (state_reg)
            ST_CLR:   cmd = htw_pkg::CMD_CLR;
            ST_IDLE:  cmd = htw_pkg::CMD_IDLE;
            ST_ASCAN: cmd = htw_pkg::CMD_ASCAN;
            ST_AFILL: cmd = htw_pkg::CMD_AFILL;
            ST_FRD:   cmd = htw_pkg::CMD_FRD;
            ST_FWR:   cmd = htw_pkg::CMD_FWR;
            ST_FLINK: cmd = htw_pkg::CMD_FLINK;
            ST_KRD:   cmd = htw_pkg::CMD_KRD;
            ST_KCMP:  cmd = htw_pkg::CMD_KCMP;
            ST_URD:   cmd = htw_pkg::CMD_URD;
            ST_UDAT:  cmd = htw_pkg::CMD_UDAT;
            ST_UWR:   cmd = htw_pkg::CMD_UWR;
            ST_EMIT:  cmd = htw_pkg::CMD_EMIT;
            ST_CRD:   cmd = htw_pkg::CMD_CRD;
            ST_CDET:  cmd = htw_pkg::CMD_CDET;
            ST_CE:    cmd = htw_pkg::CMD_CE;
            ST_CDAT:  cmd = htw_pkg::CMD_CDAT;
            ST_CNX:   cmd = htw_pkg::CMD_CNX;
            ST_TRD:   cmd = htw_pkg::CMD_TRD;
            ST_TDET:  cmd = htw_pkg::CMD_TDET;
            ST_TE:    cmd = htw_pkg::CMD_TE;
            ST_TDAT:  cmd = htw_pkg::CMD_TDAT;
            ST_TFIRE: cmd = htw_pkg::CMD_TFIRE;
            ST_TNX:   cmd = htw_pkg::CMD_TNX;
            ST_TEND:  cmd = htw_pkg::CMD_TEND;
            default:  cmd = htw_pkg::CMD_IDLE;
        endcase
    end

endmodule

/* hdl/htw_dp.sv */
// ----------------------------------------------------------------------------
// htw_dp
// Datapath: time and handle counters, entry pool RAMs, slot RAM, result regs.
// ----------------------------------------------------------------------------
module htw_dp #(
    parameter int MAX_TIMERS = htw_pkg::MAX_TIMERS_DEF,
    parameter int ROOT_BITS  = htw_pkg::ROOT_BITS_DEF,
    parameter int LEVEL_BITS = htw_pkg::LEVEL_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  htw_pkg::cmd_t       cmd,
    output htw_pkg::stat_t      stat,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_mode,
    input  logic [31:0]         s_interval,
    input  logic signed [31:0]  s_repeat_count,
    input  logic [31:0]         s_kill_handle,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_kind,
    output logic [31:0]         m_handle,
    output logic                m_last
);

    localparam int EW         = $clog2(MAX_TIMERS);
    localparam int IW         = $clog2(MAX_TIMERS + 1);
    localparam int ROOT_SIZE  = 1 << ROOT_BITS;
    localparam int LEVEL_SIZE = 1 << LEVEL_BITS;
    localparam int NUM_SLOTS  = ROOT_SIZE + 4 * LEVEL_SIZE;
    localparam int SW         = $clog2(NUM_SLOTS);
    localparam int CW         = $clog2(htw_pkg::RESULT_CAP + 1);
    localparam logic [IW-1:0] NIL = IW'(MAX_TIMERS);

    function automatic logic [31:0] level_idx(input logic [31:0] t, input logic [1:0] k);
        logic [63:0] sh;
        sh = {32'd0, t} >> (ROOT_BITS + int'(k) * LEVEL_BITS);
        return sh[31:0] & 32'(LEVEL_SIZE - 1);
    endfunction

    function automatic logic [SW-1:0] level_slot(input logic [31:0] t, input logic [1:0] k);
        logic [31:0] s;
        s = 32'(ROOT_SIZE) + 32'(k) * 32'(LEVEL_SIZE) + level_idx(t, k);
        return s[SW-1:0];
    endfunction

    function automatic logic [SW-1:0] file_slot(input logic [31:0] ex, input logic [31:0] now);
        logic [31:0]   d;
        logic [1:0]    k;
        logic [SW-1:0] s;
        d = ex - now;
        k = 2'd3;
        for (int j = 2; j >= 0; j--) begin
            if ({32'd0, d} < (64'd1 << (ROOT_BITS + (j + 1) * LEVEL_BITS))) k = 2'(j);
        end
        if (d < 32'(ROOT_SIZE)) s = {{(SW - ROOT_BITS){1'b0}}, ex[ROOT_BITS-1:0]};
        else s = level_slot(ex, k);
        return s;
    endfunction

    logic [31:0]           cur_reg, nh_reg, iv_reg, rc_reg, kh_reg, fexp_reg;
    logic [MAX_TIMERS-1:0] used_reg;
    logic [IW-1:0]         c_reg, e_reg, nx_reg, p_reg, n_reg;
    logic [SW-1:0]         fs_reg, us_reg, clr_reg;
    logic [1:0]            lvl_reg;
    logic [CW-1:0]         cnt_reg;
    htw_pkg::ent_t         d_reg;
    logic                  pend_v_reg;
    logic [31:0]           pend_h_reg, res_h_reg;
    logic [2:0]            res_kind_reg;
    logic                  m_valid_reg, m_last_reg;
    logic [2:0]            m_kind_reg;
    logic [31:0]           m_handle_reg;

    logic                  sl_we, nr_we, pr_we, es_we, dr_we;
    logic [SW-1:0]         sl_wa, sl_ra, es_wd, es_rd;
    logic [2*IW-1:0]       sl_wd, sl_rd;
    logic [EW-1:0]         nr_wa, pr_wa, es_wa, dr_wa, dr_ra;
    logic [IW-1:0]         nr_wd, pr_wd, nr_rd, pr_rd;
    htw_pkg::ent_t         dr_wd, dr_rd;

    logic [IW-1:0]  head, tail;
    logic [SW-1:0]  cslot, idx_slot, fslot;
    logic [31:0]    hnew, f1;
    logic           out_free, cap_ok, used_c, c_last, hit, again, stall, tend_go, load;

    assign head     = sl_rd[2*IW-1:IW];
    assign tail     = sl_rd[IW-1:0];
    assign cslot    = level_slot(cur_reg, lvl_reg);
    assign idx_slot = {{(SW - ROOT_BITS){1'b0}}, cur_reg[ROOT_BITS-1:0]};
    assign fslot    = file_slot(fexp_reg, cur_reg);
    assign hnew     = (nh_reg + 32'd1 == 32'd0) ? 32'd1 : nh_reg + 32'd1;
    assign f1       = d_reg.fired + 32'd1;
    assign out_free = !m_valid_reg || m_ready;
    assign cap_ok   = cnt_reg < CW'(htw_pkg::RESULT_CAP);
    assign used_c   = used_reg[c_reg[EW-1:0]];
    assign c_last   = c_reg == IW'(MAX_TIMERS - 1);
    assign hit      = used_c && dr_rd.id == kh_reg && kh_reg != 32'd0;
    assign again    = (d_reg.limit == htw_pkg::LIMIT_FOREVER) ? 1'b1 :
                      d_reg.limit[31] ? 1'b0 : (f1 < d_reg.limit);
    assign stall    = cap_ok && pend_v_reg && !out_free;
    assign tend_go  = !pend_v_reg || out_free;

    assign stat.acc        = s_valid;
    assign stat.mode       = s_mode;
    assign stat.root_zero  = cur_reg[ROOT_BITS-1:0] == '0;
    assign stat.used_c     = used_c;
    assign stat.c_last     = c_last;
    assign stat.kill_hit   = hit;
    assign stat.tail_nil   = tail == NIL;
    assign stat.e_nil      = e_reg == NIL;
    assign stat.casc_brk   = level_idx(cur_reg, lvl_reg) != 32'd0 || lvl_reg == 2'd3;
    assign stat.out_free   = out_free;
    assign stat.clr_last   = clr_reg == SW'(NUM_SLOTS - 1);
    assign stat.fire_stall = stall;
    assign stat.again      = again;
    assign stat.pend_v     = pend_v_reg;

    assign s_ready = cmd == htw_pkg::CMD_IDLE;

    always_comb begin
        sl_we = 1'b0; sl_wa = '0; sl_wd = {NIL, NIL};
        nr_we = 1'b0; nr_wa = e_reg[EW-1:0]; nr_wd = NIL;
        pr_we = 1'b0; pr_wa = e_reg[EW-1:0]; pr_wd = tail;
        es_we = 1'b0; es_wa = e_reg[EW-1:0]; es_wd = fs_reg;
        dr_we = 1'b0; dr_wa = e_reg[EW-1:0]; dr_wd = d_reg;
        dr_ra = (cmd == htw_pkg::CMD_KRD) ? c_reg[EW-1:0] : e_reg[EW-1:0];
        case (cmd)
            htw_pkg::CMD_FRD:  sl_ra = fslot;
            htw_pkg::CMD_UDAT: sl_ra = es_rd;
            htw_pkg::CMD_CRD:  sl_ra = cslot;
            htw_pkg::CMD_TRD:  sl_ra = idx_slot;
            default:           sl_ra = '0;
        endcase
        case (cmd)
            htw_pkg::CMD_CLR: begin
                sl_we = 1'b1;
                sl_wa = clr_reg;
            end
            htw_pkg::CMD_AFILL: begin
                dr_we = 1'b1;
                dr_wd = '{expiry: cur_reg + iv_reg, period: iv_reg, limit: rc_reg,
                          fired: 32'd0, id: hnew};
            end
            htw_pkg::CMD_FWR: begin
                sl_we = 1'b1;
                sl_wa = fs_reg;
                sl_wd = {(tail == NIL) ? e_reg : head, e_reg};
                es_we = 1'b1;
                nr_we = 1'b1;
                pr_we = 1'b1;
            end
            htw_pkg::CMD_FLINK: begin
                nr_we = 1'b1;
                nr_wa = p_reg[EW-1:0];
                nr_wd = e_reg;
            end
            htw_pkg::CMD_UWR: begin
                nr_we = p_reg != NIL;
                nr_wa = p_reg[EW-1:0];
                nr_wd = n_reg;
                pr_we = n_reg != NIL;
                pr_wa = n_reg[EW-1:0];
                pr_wd = p_reg;
                sl_we = p_reg == NIL || n_reg == NIL;
                sl_wa = us_reg;
                sl_wd = {(p_reg == NIL) ? n_reg : head, (n_reg == NIL) ? p_reg : tail};
            end
            htw_pkg::CMD_CDET: begin
                sl_we = 1'b1;
                sl_wa = cslot;
            end
            htw_pkg::CMD_TDET: begin
                sl_we = 1'b1;
                sl_wa = idx_slot;
            end
            htw_pkg::CMD_TFIRE: begin
                dr_we = !stall;
                dr_wd.fired = f1;
                if (again) dr_wd.expiry = cur_reg + d_reg.period;
            end
            default: begin
                sl_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg    <= '0;
            nh_reg     <= '0;
            used_reg   <= '0;
            pend_v_reg <= 1'b0;
            clr_reg    <= '0;
        end else begin
            case (cmd)
                htw_pkg::CMD_CLR: clr_reg <= clr_reg + SW'(1);
                htw_pkg::CMD_IDLE: begin
                    if (s_valid) begin
                        iv_reg  <= (s_interval == 32'd0) ? 32'd1 : s_interval;
                        rc_reg  <= $unsigned(s_repeat_count);
                        kh_reg  <= s_kill_handle;
                        c_reg   <= '0;
                        lvl_reg <= '0;
                        cnt_reg <= '0;
                    end
                end
                htw_pkg::CMD_ASCAN: begin
                    if (!used_c) begin
                        e_reg <= c_reg;
                    end else if (!c_last) begin
                        c_reg <= c_reg + IW'(1);
                    end else begin
                        res_kind_reg <= htw_pkg::KIND_FULL;
                        res_h_reg    <= 32'd0;
                    end
                end
                htw_pkg::CMD_AFILL: begin
                    nh_reg                   <= hnew;
                    used_reg[e_reg[EW-1:0]]  <= 1'b1;
                    fexp_reg                 <= cur_reg + iv_reg;
                    res_kind_reg             <= htw_pkg::KIND_ADDED;
                    res_h_reg                <= hnew;
                end
                htw_pkg::CMD_FRD: fs_reg <= fslot;
                htw_pkg::CMD_FWR: p_reg <= tail;
                htw_pkg::CMD_KCMP: begin
                    if (hit) begin
                        e_reg <= c_reg;
                    end else if (!c_last) begin
                        c_reg <= c_reg + IW'(1);
                    end else begin
                        res_kind_reg <= htw_pkg::KIND_MISS;
                        res_h_reg    <= kh_reg;
                    end
                end
                htw_pkg::CMD_UDAT: begin
                    p_reg  <= pr_rd;
                    n_reg  <= nr_rd;
                    us_reg <= es_rd;
                end
                htw_pkg::CMD_UWR: begin
                    used_reg[e_reg[EW-1:0]] <= 1'b0;
                    res_kind_reg            <= htw_pkg::KIND_KILLED;
                    res_h_reg               <= kh_reg;
                end
                htw_pkg::CMD_CDET, htw_pkg::CMD_TDET: e_reg <= head;
                htw_pkg::CMD_CE: begin
                    if (e_reg == NIL && !stat.casc_brk) lvl_reg <= lvl_reg + 2'd1;
                end
                htw_pkg::CMD_CDAT: begin
                    nx_reg   <= nr_rd;
                    fexp_reg <= dr_rd.expiry;
                end
                htw_pkg::CMD_CNX, htw_pkg::CMD_TNX: e_reg <= nx_reg;
                htw_pkg::CMD_TDAT: begin
                    nx_reg <= nr_rd;
                    d_reg  <= dr_rd;
                end
                htw_pkg::CMD_TFIRE: begin
                    if (!stall) begin
                        if (cap_ok) begin
                            pend_v_reg <= 1'b1;
                            pend_h_reg <= d_reg.id;
                            cnt_reg    <= cnt_reg + CW'(1);
                        end
                        if (again) fexp_reg <= cur_reg + d_reg.period;
                        else used_reg[e_reg[EW-1:0]] <= 1'b0;
                    end
                end
                htw_pkg::CMD_TEND: begin
                    if (tend_go) begin
                        pend_v_reg <= 1'b0;
                        cur_reg    <= cur_reg + 32'd1;
                    end
                end
                default: begin
                    clr_reg <= clr_reg;
                end
            endcase
        end
    end

    // result register; a fired item is held back one step so that last can be set
    assign load = (cmd == htw_pkg::CMD_EMIT && out_free)
               || (cmd == htw_pkg::CMD_TFIRE && !stall && cap_ok && pend_v_reg)
               || (cmd == htw_pkg::CMD_TEND && pend_v_reg && out_free);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            if (cmd == htw_pkg::CMD_EMIT) begin
                m_kind_reg   <= res_kind_reg;
                m_handle_reg <= res_h_reg;
                m_last_reg   <= 1'b1;
            end else begin
                m_kind_reg   <= htw_pkg::KIND_FIRED;
                m_handle_reg <= pend_h_reg;
                m_last_reg   <= cmd == htw_pkg::CMD_TEND;
            end
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_kind   = m_kind_reg;
    assign m_handle = m_handle_reg;
    assign m_last   = m_last_reg;

    htw_ram #(.WIDTH(2 * IW), .DEPTH(NUM_SLOTS)) u_slot_ram (
        .aclk(aclk), .we(sl_we), .waddr(sl_wa), .wdata(sl_wd), .raddr(sl_ra), .rdata(sl_rd)
    );
    htw_ram #(.WIDTH(IW), .DEPTH(MAX_TIMERS)) u_next_ram (
        .aclk(aclk), .we(nr_we), .waddr(nr_wa), .wdata(nr_wd),
        .raddr(e_reg[EW-1:0]), .rdata(nr_rd)
    );
    htw_ram #(.WIDTH(IW), .DEPTH(MAX_TIMERS)) u_prev_ram (
        .aclk(aclk), .we(pr_we), .waddr(pr_wa), .wdata(pr_wd),
        .raddr(e_reg[EW-1:0]), .rdata(pr_rd)
    );
    htw_ram #(.WIDTH(SW), .DEPTH(MAX_TIMERS)) u_eslot_ram (
        .aclk(aclk), .we(es_we), .waddr(es_wa), .wdata(es_wd),
        .raddr(e_reg[EW-1:0]), .rdata(es_rd)
    );
    htw_ram #(.WIDTH($bits(htw_pkg::ent_t)), .DEPTH(MAX_TIMERS)) u_data_ram (
        .aclk(aclk), .we(dr_we), .waddr(dr_wa), .wdata(dr_wd), .raddr(dr_ra), .rdata(dr_rd)
    );

    a_file_entry_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd == htw_pkg::CMD_FWR |-> e_reg != NIL)
        else $error("filing an empty entry index");

    a_no_pending_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd == htw_pkg::CMD_IDLE |-> !pend_v_reg)
        else $error("fired item left pending after tick");

    a_tick_closes_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == htw_pkg::CMD_TEND && pend_v_reg && out_free)
        |=> (m_valid_reg && m_last_reg && m_kind_reg == htw_pkg::KIND_FIRED))
        else $error("final fired item not marked last");

endmodule

/* hdl/hierarchical_timer_wheel_top.sv */
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel_top
// Five-level timer wheel over a fixed pool of timers; add, kill and tick items.
// ----------------------------------------------------------------------------
//   channel   direction  ports
//   s_        in         s_valid s_ready s_mode s_interval s_repeat_count s_kill_handle
//   m_        out        m_valid m_ready m_kind m_handle m_last
//
// After reset the slot RAM is cleared, one slot a cycle, with s_ready low.
// Add: scans the pool for the lowest free entry, then fills it and files it in its slot.
// Kill: compares pool entries in turn with the handle; a match is unlinked, else a miss is reported.
// Tick: on a root wrap, cascades the due level slots and refiles their timers; then fires the root slot.
// A stalled m_ready holds the walk only when a new item must go out.
module hierarchical_timer_wheel_top #(
    parameter int MAX_TIMERS = htw_pkg::MAX_TIMERS_DEF,
    parameter int ROOT_BITS  = htw_pkg::ROOT_BITS_DEF,
    parameter int LEVEL_BITS = htw_pkg::LEVEL_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic [31:0]        s_interval,
    input  logic signed [31:0] s_repeat_count,
    input  logic [31:0]        s_kill_handle,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_kind,
    output logic [31:0]        m_handle,
    output logic               m_last
);

    htw_pkg::cmd_t  cmd;
    htw_pkg::stat_t stat;

    htw_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .stat(stat), .cmd(cmd)
    );

    htw_dp #(
        .MAX_TIMERS(MAX_TIMERS), .ROOT_BITS(ROOT_BITS), .LEVEL_BITS(LEVEL_BITS)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode), .s_interval(s_interval),
        .s_repeat_count(s_repeat_count), .s_kill_handle(s_kill_handle),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind), .m_handle(m_handle),
        .m_last(m_last)
    );

endmodule

/* bench/hierarchical_timer_wheel_top_tb.sv */
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel_top_tb
// Checks the timer wheel against a predictor kept in step with every accepted
// item: adds, kills, ticks, pool exhaustion, cascades and random traffic.
// ----------------------------------------------------------------------------
module hierarchical_timer_wheel_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NTIM      = htw_pkg::MAX_TIMERS_DEF;
    localparam int ROOT_SZ   = 1 << htw_pkg::ROOT_BITS_DEF;
    localparam int LVL_SZ    = 1 << htw_pkg::LEVEL_BITS_DEF;
    localparam int NSLOT     = ROOT_SZ + 4 * LVL_SZ;
    localparam int NIL       = NTIM;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 30;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] handle;
        logic        last;
    } result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_mode = htw_pkg::MODE_TICK;
    logic [31:0]        s_interval = '0;
    logic signed [31:0] s_repeat_count = '0;
    logic [31:0]        s_kill_handle = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [2:0]         m_kind;
    logic [31:0]        m_handle;
    logic               m_last;

    hierarchical_timer_wheel_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_interval(s_interval), .s_repeat_count(s_repeat_count),
        .s_kill_handle(s_kill_handle),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_handle(m_handle), .m_last(m_last)
    );

    always #6 aclk = ~aclk;

    // wheel state mirror
    logic [31:0] now_t;
    logic [31:0] handle_ctr;
    int          head_of[NSLOT];
    int          tail_of[NSLOT];
    int          nxt[NTIM];
    int          prv[NTIM];
    int          slot_of[NTIM];
    logic [31:0] expiry[NTIM];
    logic [31:0] period[NTIM];
    logic [31:0] limit[NTIM];
    logic [31:0] fire_cnt[NTIM];
    logic [31:0] tid[NTIM];
    bit          busy[NTIM];

    result_t     pending_q[$];
    int          mismatches = 0;
    bit          quiet = 1'b0;
    int          stall_left = 0;
    int          wdog = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void wheel_clear();
        now_t = '0;
        handle_ctr = '0;
        for (int i = 0; i < NSLOT; i++) begin
            head_of[i] = NIL;
            tail_of[i] = NIL;
        end
        for (int i = 0; i < NTIM; i++) busy[i] = 1'b0;
    endfunction

    function automatic void file_timer(int e);
        logic [31:0] ex;
        logic [31:0] dly;
        int s;
        int k;
        ex = expiry[e];
        dly = ex - now_t;
        if (dly < ROOT_SZ) begin
            s = int'(ex & (ROOT_SZ - 1));
        end else begin
            k = 0;
            while (k < 3 && 64'(dly) >= (64'd1 << (htw_pkg::ROOT_BITS_DEF
                                                    + (k + 1) * htw_pkg::LEVEL_BITS_DEF)))
                k++;
            s = ROOT_SZ + k * LVL_SZ
                + int'((ex >> (htw_pkg::ROOT_BITS_DEF + k * htw_pkg::LEVEL_BITS_DEF))
                       & (LVL_SZ - 1));
        end
        slot_of[e] = s;
        nxt[e] = NIL;
        prv[e] = tail_of[s];
        if (tail_of[s] == NIL) head_of[s] = e;
        else nxt[tail_of[s]] = e;
        tail_of[s] = e;
    endfunction

    function automatic int take_slot(int s);
        int h;
        h = head_of[s];
        head_of[s] = NIL;
        tail_of[s] = NIL;
        return h;
    endfunction

    function automatic void wheel_step(logic [1:0] md, logic [31:0] iv, logic [31:0] rc,
                                       logic [31:0] kh);
        result_t r[$];
        result_t one;
        int e;
        int nx;
        int li;
        bit again;
        if (md == htw_pkg::MODE_ADD) begin
            for (e = 0; e < NTIM && busy[e]; e++) ;
            if (e >= NTIM) begin
                one = '{htw_pkg::KIND_FULL, 32'd0, 1'b0};
                r.push_back(one);
            end else begin
                handle_ctr = handle_ctr + 32'd1;
                if (handle_ctr == 32'd0) handle_ctr = 32'd1;
                if (iv == 32'd0) iv = 32'd1;
                busy[e] = 1'b1;
                tid[e] = handle_ctr;
                period[e] = iv;
                limit[e] = rc;
                fire_cnt[e] = 32'd0;
                expiry[e] = now_t + iv;
                file_timer(e);
                one = '{htw_pkg::KIND_ADDED, handle_ctr, 1'b0};
                r.push_back(one);
            end
        end else if (md == htw_pkg::MODE_KILL) begin
            for (e = 0; e < NTIM; e++)
                if (busy[e] && tid[e] == kh && kh != 32'd0) break;
            if (e >= NTIM) begin
                one = '{htw_pkg::KIND_MISS, kh, 1'b0};
            end else begin
                if (prv[e] == NIL) head_of[slot_of[e]] = nxt[e];
                else nxt[prv[e]] = nxt[e];
                if (nxt[e] == NIL) tail_of[slot_of[e]] = prv[e];
                else prv[nxt[e]] = prv[e];
                busy[e] = 1'b0;
                one = '{htw_pkg::KIND_KILLED, kh, 1'b0};
            end
            r.push_back(one);
        end else if (md == htw_pkg::MODE_TICK) begin
            if ((now_t & (ROOT_SZ - 1)) == 0) begin
                for (int k = 0; k < 4; k++) begin
                    li = int'((now_t >> (htw_pkg::ROOT_BITS_DEF + k * htw_pkg::LEVEL_BITS_DEF))
                              & (LVL_SZ - 1));
                    e = take_slot(ROOT_SZ + k * LVL_SZ + li);
                    while (e != NIL) begin
                        nx = nxt[e];
                        file_timer(e);
                        e = nx;
                    end
                    if (li != 0) break;
                end
            end
            e = take_slot(int'(now_t & (ROOT_SZ - 1)));
            while (e != NIL) begin
                nx = nxt[e];
                fire_cnt[e] = fire_cnt[e] + 32'd1;
                if (r.size() < htw_pkg::RESULT_CAP) begin
                    one = '{htw_pkg::KIND_FIRED, tid[e], 1'b0};
                    r.push_back(one);
                end
                if (limit[e] == htw_pkg::LIMIT_FOREVER) again = 1'b1;
                else if (limit[e][31]) again = 1'b0;
                else again = fire_cnt[e] < limit[e];
                if (again) begin
                    expiry[e] = now_t + period[e];
                    file_timer(e);
                end else begin
                    busy[e] = 1'b0;
                end
                e = nx;
            end
            now_t = now_t + 32'd1;
        end
        if (r.size() > 0) r[r.size() - 1].last = 1'b1;
        foreach (r[i]) pending_q.push_back(r[i]);
    endfunction

    task automatic send_item(logic [1:0] md, logic [31:0] iv, logic [31:0] rc,
                             logic [31:0] kh);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= md;
        s_interval <= iv;
        s_repeat_count <= rc;
        s_kill_handle <= kh;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        wheel_step(md, iv, rc, kh);
    endtask

    task automatic tick_n(int n);
        repeat (n) send_item(htw_pkg::MODE_TICK, $urandom, $urandom, $urandom);
    endtask

    task automatic kill_all_live();
        for (int e = 0; e < NTIM; e++)
            if (busy[e]) send_item(htw_pkg::MODE_KILL, $urandom, $urandom, tid[e]);
    endtask

    // drain before a new phase so kills by handle see settled state
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_item(htw_pkg::MODE_ADD, 32'd0, 32'd0, 32'd0);
        send_item(htw_pkg::MODE_ADD, 32'd1, 32'hffff_ffff, 32'hffff_ffff);
        send_item(htw_pkg::MODE_ADD, 32'hffff_ffff, 32'h7fff_ffff, 32'd0);
        send_item(htw_pkg::MODE_ADD, 32'd5, -32'sd5, 32'd0);
        send_item(htw_pkg::MODE_ADD, 32'd3, 32'd3, 32'd0);
        send_item(htw_pkg::MODE_ADD, 32'd255, 32'd1, 32'd0);
        send_item(htw_pkg::MODE_ADD, 32'd256, 32'd2, 32'd0);
        send_item(htw_pkg::MODE_ADD, 32'd2, 32'h8000_0000, 32'd0);
        tick_n(10);
        send_item(htw_pkg::MODE_KILL, 32'd0, 32'd0, 32'd2);
        send_item(htw_pkg::MODE_KILL, 32'hffff_ffff, 32'hffff_ffff, 32'd2);
        send_item(htw_pkg::MODE_KILL, 32'd0, 32'd0, 32'd0);
        send_item(htw_pkg::MODE_KILL, 32'd0, 32'd0, 32'hffff_ffff);
        send_item(2'd3, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_item(htw_pkg::MODE_KILL, 32'd0, 32'd0, 32'd3);
        tick_n(3);
        kill_all_live();
    endtask

    task automatic test_pool_full();
        for (int i = 0; i <= NTIM; i++)
            send_item(htw_pkg::MODE_ADD, 32'h4000_0000 | $urandom, $urandom_range(0, 9),
                      32'd0);
        kill_all_live();
    endtask

    task automatic test_cascade();
        logic [31:0] ivs[10] = '{32'd256, 32'd257, 32'd260, 32'd265, 32'd300, 32'd511,
                                 32'd512, 32'd4000, 32'd16384, 32'd70000};
        foreach (ivs[i]) send_item(htw_pkg::MODE_ADD, ivs[i], 32'd1, 32'd0);
        send_item(htw_pkg::MODE_ADD, 32'd1000, 32'hffff_ffff, 32'd0);
        send_item(htw_pkg::MODE_ADD, 32'd7, 32'hffff_ffff, 32'd0);
        quiet = 1'b1;
        tick_n(270);
        quiet = 1'b0;
        kill_all_live();
    endtask

    task automatic test_random();
        int r;
        int e;
        logic [31:0] iv;
        logic [31:0] rc;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 30 == 15) quiet = 1'b1;
            if (i % 30 == 25) quiet = 1'b0;
            r = $urandom_range(0, 99);
            if (r < 45) begin
                tick_n(1);
            end else if (r < 78) begin
                r = $urandom_range(0, 99);
                if (r < 70) iv = $urandom_range(0, 24);
                else if (r < 92) iv = $urandom_range(200, 1200);
                else iv = $urandom;
                r = $urandom_range(0, 99);
                if (r < 60) rc = $urandom_range(0, 4);
                else if (r < 75) rc = 32'hffff_ffff;
                else rc = $urandom;
                send_item(htw_pkg::MODE_ADD, iv, rc, $urandom);
            end else if (r < 97) begin
                e = $urandom_range(0, NTIM - 1);
                send_item(htw_pkg::MODE_KILL, $urandom, $urandom,
                          busy[e] ? tid[e] : $urandom_range(0, 600));
            end else begin
                send_item(2'd3, $urandom, $urandom, $urandom);
            end
        end
    endtask

    // result side: random back-pressure and checking
    always @(posedge aclk) begin
        result_t want;
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (aresetn && !quiet && $urandom_range(0, 99) < 25) stall_left <= pick_gap();
        end
        if (m_valid && m_ready) begin
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: kind %0d handle %0h last %0b",
                             m_kind, m_handle, m_last);
            end else begin
                want = pending_q[0];
                pending_q.delete(0);
                if (m_kind !== want.kind || m_handle !== want.handle
                        || m_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp kind %0d handle %0h last %0b, got %0d %0h %0b",
                                 want.kind, want.handle, want.last,
                                 m_kind, m_handle, m_last);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) wdog <= 0;
        else wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        wheel_clear();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        drain();
        test_pool_full();
        drain();
        test_cascade();
        drain();
        test_random();
        drain();
        repeat (300) @(posedge aclk);
        if (mismatches == 0 && pending_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/htw_pkg.sv
hdl/htw_ram.sv
hdl/htw_ctrl.sv
hdl/htw_dp.sv
hdl/hierarchical_timer_wheel_top.sv
bench/hierarchical_timer_wheel_top_tb.sv
